// File: rtl/core/ll1ps_pkg.sv
// Package for the LL(1) table parser step block.
// Holds sizes, request and event codes and the payload structs; no dependencies.
package ll1ps_pkg;

  localparam int unsigned NumTerminals    = 64;
  localparam int unsigned NumNonterminals = 64;
  localparam int unsigned NumProductions  = 256;
  localparam int unsigned MaxProdLen      = 8;
  localparam int unsigned StackDepth      = 256;
  localparam int unsigned MaxActions      = 64;

  localparam int unsigned TblAw = 12;
  localparam int unsigned SymAw = 11;
  localparam int unsigned StkAw = 8;
  localparam int unsigned SpW   = 9;
  localparam int unsigned CntW  = 6;

  localparam logic [2:0] ReqToken   = 3'd0;
  localparam logic [2:0] ReqCell    = 3'd1;
  localparam logic [2:0] ReqSymbol  = 3'd2;
  localparam logic [2:0] ReqLength  = 3'd3;
  localparam logic [2:0] ReqRestart = 3'd4;

  localparam logic [1:0] KindEmpty = 2'd0;
  localparam logic [1:0] KindProd  = 2'd1;
  localparam logic [1:0] KindSync  = 2'd2;
  localparam logic [1:0] KindBad   = 2'd3;

  localparam logic [3:0] EvExpand   = 4'd0;
  localparam logic [3:0] EvSyncPop  = 4'd1;
  localparam logic [3:0] EvDiscard  = 4'd2;
  localparam logic [3:0] EvMissPop  = 4'd3;
  localparam logic [3:0] EvMatch    = 4'd4;
  localparam logic [3:0] EvAccept   = 4'd5;
  localparam logic [3:0] EvOverflow = 4'd6;
  localparam logic [3:0] EvStepLim  = 4'd7;
  localparam logic [3:0] EvConflict = 4'd8;

  localparam logic [0:0] RegStartSymbol = 1'b0;

  typedef struct packed {
    logic [2:0] req_type;
    logic [5:0] token;
    logic [5:0] nonterminal;
    logic [1:0] entry_kind;
    logic [7:0] production;
    logic [2:0] position;
    logic [6:0] symbol;
    logic [3:0] prod_length;
  } in_req_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic [5:0] rule_lhs;
    logic [7:0] rule_index;
    logic [5:0] terminal_seen;
    logic [8:0] stack_depth;
    logic       last;
  } out_res_t;

endpackage

// File: rtl/core/ll1_table_parser_step.sv
// Top level of the LL(1) table parser step block with panic-mode recovery.
// Depends on ll1ps_pkg and ll1ps_cfg.
// After reset the parse table is cleared by a pass over all 4096 entries, during which no
// request is taken. A symbol or length request is written when it is accepted; a restart and
// a cell write pass through their own states. A token request is accepted, and then one
// sequencer walks the stack memory, the parse table and the production memories for a
// terminal match or pop, a sync pop, a discard, an expansion with its pushed symbols, an
// overflow, a step limit or the accept. A result waits in an output register
// and each of these steps lasts longer while out_stall_i holds that register full.
module ll1_table_parser_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ll1ps_pkg::in_req_t   in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ll1ps_pkg::out_res_t  out_res_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  typedef enum logic [12:0] {
    S_CLR     = 13'h0001,
    S_IDLE    = 13'h0002,
    S_RST     = 13'h0004,
    S_CW_RD   = 13'h0008,
    S_CW_CHK  = 13'h0010,
    S_CHECK   = 13'h0020,
    S_TOP     = 13'h0040,
    S_LOOK    = 13'h0080,
    S_CELL    = 13'h0100,
    S_LEN     = 13'h0200,
    S_PUSH_RD = 13'h0400,
    S_PUSH_WR = 13'h0800,
    S_ACC     = 13'h1000
  } state_e;

  state_e state_q, state_d;

  logic [5:0] start_sym;

  logic [9:0] tbl_mem [ll1ps_pkg::NumNonterminals * ll1ps_pkg::NumTerminals];
  logic [6:0] sym_mem [ll1ps_pkg::NumProductions * ll1ps_pkg::MaxProdLen];
  logic [3:0] len_mem [ll1ps_pkg::NumProductions];
  logic [6:0] stk_mem [ll1ps_pkg::StackDepth];

  logic [9:0] tbl_rd_q;
  logic [6:0] sym_rd_q;
  logic [3:0] len_rd_q;
  logic [6:0] stk_rd_q;

  logic [ll1ps_pkg::TblAw-1:0] clr_q, clr_d;
  logic [ll1ps_pkg::SpW-1:0]   sp_q, sp_d;
  logic [ll1ps_pkg::CntW-1:0]  n_q, n_d;
  logic [3:0]                  cnt_q, cnt_d;
  logic [5:0]                  row_q, row_d;
  logic [5:0]                  tok_q, tok_d;
  logic [1:0]                  kind_q, kind_d;
  logic [7:0]                  prod_q, prod_d;

  logic                        out_valid_q, out_valid_d;
  ll1ps_pkg::out_res_t         out_q, out_d;
  logic                        out_free;

  logic                        tbl_we;
  logic [ll1ps_pkg::TblAw-1:0] tbl_waddr;
  logic [9:0]                  tbl_wdata;
  logic [ll1ps_pkg::TblAw-1:0] tbl_raddr;
  logic                        stk_we;
  logic [ll1ps_pkg::StkAw-1:0] stk_waddr;
  logic [6:0]                  stk_wdata;
  logic [ll1ps_pkg::StkAw-1:0] stk_raddr;
  logic [7:0]                  len_raddr;
  logic [ll1ps_pkg::SymAw-1:0] sym_raddr;
  logic                        sym_we;
  logic                        len_we;
  logic [3:0]                  len_sat;
  logic [9:0]                  need;
  logic [ll1ps_pkg::SpW-1:0]   sp_dec;
  logic                        acc;

  ll1ps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start_o (start_sym)
  );

  function automatic ll1ps_pkg::out_res_t mk_res(
    input logic [3:0] ev, input logic [5:0] lhs, input logic [7:0] rule,
    input logic [5:0] tok, input logic [8:0] depth, input logic last);
    ll1ps_pkg::out_res_t r;
    r.event_res     = ev;
    r.rule_lhs      = lhs;
    r.rule_index    = rule;
    r.terminal_seen = tok;
    r.stack_depth   = depth;
    r.last          = last;
    return r;
  endfunction

  assign acc         = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign sp_dec    = sp_q - 9'd1;
  assign stk_raddr = sp_dec[ll1ps_pkg::StkAw-1:0];
  assign tbl_raddr = {row_q, tok_q};
  assign len_raddr = (state_q == S_CELL) ? tbl_rd_q[7:0] : prod_q;
  assign sym_raddr = {prod_q, 3'(cnt_q - 4'd1)};
  assign need      = {1'b0, sp_dec} + {6'd0, len_rd_q};
  assign len_sat   = (in_req_i.prod_length > 4'd8) ? 4'd8 : in_req_i.prod_length;
  assign sym_we    = acc && (in_req_i.req_type == ll1ps_pkg::ReqSymbol);
  assign len_we    = acc && (in_req_i.req_type == ll1ps_pkg::ReqLength);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    sp_d        = sp_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    row_d       = row_q;
    tok_d       = tok_q;
    kind_d      = kind_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    tbl_we      = 1'b0;
    tbl_waddr   = clr_q;
    tbl_wdata   = 10'd0;
    stk_we      = 1'b0;
    stk_waddr   = sp_q[ll1ps_pkg::StkAw-1:0];
    stk_wdata   = sym_rd_q;
    case (state_q)
      S_CLR: begin
        tbl_we = 1'b1;
        clr_d  = clr_q + 12'd1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          tok_d  = in_req_i.token;
          row_d  = in_req_i.nonterminal;
          kind_d = in_req_i.entry_kind;
          prod_d = in_req_i.production;
          n_d    = '0;
          case (in_req_i.req_type)
            ll1ps_pkg::ReqToken: state_d = S_CHECK;
            ll1ps_pkg::ReqCell: begin
              if (in_req_i.entry_kind != ll1ps_pkg::KindBad) begin
                state_d = S_CW_RD;
              end
            end
            ll1ps_pkg::ReqRestart: begin
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = 7'd0;
              state_d   = S_RST;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RST: begin
        stk_we    = 1'b1;
        stk_waddr = 8'd1;
        stk_wdata = {1'b1, start_sym};
        sp_d      = 9'd2;
        state_d   = S_IDLE;
      end
      S_CW_RD: state_d = S_CW_CHK;
      S_CW_CHK: begin
        if (tbl_rd_q[9:8] != ll1ps_pkg::KindEmpty) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d = mk_res(ll1ps_pkg::EvConflict, row_q, 8'd0, tok_q, sp_q, 1'b1);
            state_d = S_IDLE;
          end
        end else begin
          tbl_we    = (kind_q != ll1ps_pkg::KindEmpty);
          tbl_waddr = {row_q, tok_q};
          tbl_wdata = {kind_q, (kind_q == ll1ps_pkg::KindProd) ? prod_q : 8'd0};
          state_d   = S_IDLE;
        end
      end
      S_CHECK: begin
        if (n_q == 6'(ll1ps_pkg::MaxActions - 1)) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d = mk_res(ll1ps_pkg::EvStepLim, 6'd0, 8'd0, tok_q, sp_q, 1'b1);
            state_d = S_IDLE;
          end
        end else if (sp_q == '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d = mk_res(ll1ps_pkg::EvDiscard, 6'd0, 8'd0, tok_q, sp_q, 1'b1);
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_TOP;
        end
      end
      S_TOP: begin
        if (stk_rd_q[6]) begin
          row_d   = stk_rd_q[5:0];
          state_d = S_LOOK;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          sp_d        = sp_dec;
          n_d         = n_q + 6'd1;
          if (stk_rd_q[5:0] == tok_q) begin
            if (tok_q == 6'd0 && sp_dec == '0) begin
              out_d   = mk_res(ll1ps_pkg::EvMatch, 6'd0, 8'd0, tok_q, sp_dec, 1'b0);
              state_d = S_ACC;
            end else begin
              out_d   = mk_res(ll1ps_pkg::EvMatch, 6'd0, 8'd0, tok_q, sp_dec, 1'b1);
              state_d = S_IDLE;
            end
          end else begin
            out_d   = mk_res(ll1ps_pkg::EvMissPop, 6'd0, 8'd0, tok_q, sp_dec, 1'b0);
            state_d = S_CHECK;
          end
        end
      end
      S_LOOK: state_d = S_CELL;
      S_CELL: begin
        case (tbl_rd_q[9:8])
          ll1ps_pkg::KindProd: begin
            prod_d  = tbl_rd_q[7:0];
            state_d = S_LEN;
          end
          ll1ps_pkg::KindSync: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_d = mk_res(ll1ps_pkg::EvSyncPop, row_q, 8'd0, tok_q, sp_dec, 1'b0);
              sp_d    = sp_dec;
              n_d     = n_q + 6'd1;
              state_d = S_CHECK;
            end
          end
          default: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_d = mk_res(ll1ps_pkg::EvDiscard, row_q, 8'd0, tok_q, sp_q, 1'b1);
              state_d = S_IDLE;
            end
          end
        endcase
      end
      S_LEN: begin
        if (need > 10'(ll1ps_pkg::StackDepth)) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d = mk_res(ll1ps_pkg::EvOverflow, row_q, prod_q, tok_q, sp_q, 1'b1);
            state_d = S_IDLE;
          end
        end else begin
          sp_d    = sp_dec;
          cnt_d   = len_rd_q;
          state_d = S_PUSH_RD;
        end
      end
      S_PUSH_RD: begin
        if (cnt_q != 4'd0) begin
          state_d = S_PUSH_WR;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d = mk_res(ll1ps_pkg::EvExpand, row_q, prod_q, tok_q, sp_q, 1'b0);
          n_d     = n_q + 6'd1;
          state_d = S_CHECK;
        end
      end
      S_PUSH_WR: begin
        stk_we  = 1'b1;
        sp_d    = sp_q + 9'd1;
        cnt_d   = cnt_q - 4'd1;
        state_d = S_PUSH_RD;
      end
      S_ACC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = mk_res(ll1ps_pkg::EvAccept, 6'd0, 8'd0, tok_q, sp_q, 1'b1);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      sp_q        <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    tok_q  <= tok_d;
    kind_q <= kind_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rd_q <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[{in_req_i.production, in_req_i.position}] <= in_req_i.symbol;
    end
    sym_rd_q <= sym_mem[sym_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[in_req_i.production] <= len_sat;
    end
    len_rd_q <= len_mem[len_raddr];
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state is not one-hot");

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= 9'(ll1ps_pkg::StackDepth)) else $error("stack pointer beyond depth");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH_WR) |-> (cnt_q != 4'd0)) else $error("push with no symbol left");

  a_idle_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR && clr_q == '1) |=> (state_q == S_IDLE))
    else $error("clearing pass did not end in idle");

endmodule

// File: rtl/core/ll1ps_cfg.sv
// APB-style configuration register file holding the start symbol.
// Depends on ll1ps_pkg for the register index.
module ll1ps_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [5:0]  start_o
);

  logic [5:0] start_q, start_d;
  logic       sel_start;

  assign sel_start = (paddr[2] == ll1ps_pkg::RegStartSymbol);
  assign pready    = 1'b1;
  assign prdata    = sel_start ? {26'd0, start_q} : 32'd0;
  assign start_o   = start_q;

  always_comb begin
    start_d = start_q;
    if (psel && penable && pwrite && sel_start) begin
      start_d = pwdata[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 6'd0;
    end else begin
      start_q <= start_d;
    end
  end

endmodule
